>>> design/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and codes for the binary max-heap engine.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_BUILD  = 3'd1;
    localparam logic [2:0] FN_DELMAX = 3'd2;
    localparam logic [2:0] FN_UPDATE = 3'd3;
    localparam logic [2:0] FN_DELAT  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [9:0]         slot;
        logic signed [31:0] key_in;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_key;
        logic signed [31:0] removed_key;
        logic [10:0]        entry_count;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_DM_A,
        S_DM_B,
        S_UP_OLD,
        S_DA_OLD,
        S_DA_LAST,
        S_BLD_NEXT,
        S_BLD_LD,
        S_SD,
        S_SD_L,
        S_SD_R,
        S_SD_ONE,
        S_SU,
        S_SU_P,
        S_TOP,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {MEM_NONE, MEM_RD, MEM_WR} mem_t;

    typedef enum logic [2:0] {
        ADR_ZERO, ADR_CNT, ADR_CNTM1, ADR_SLOT, ADR_IDX, ADR_LEFT, ADR_RIGHT,
        ADR_PARENT
    } adr_t;

    typedef enum logic [1:0] {WD_KEY, WD_V, WD_REMOVED, WD_RDATA} wd_t;

    typedef enum logic [2:0] {
        IDX_ZERO, IDX_SLOT, IDX_LEFT, IDX_CHILD, IDX_PARENT, IDX_BLD
    } isel_t;

    typedef struct packed {
        logic       latch;
        mem_t       mem;
        adr_t       adr;
        wd_t        wd;
        logic       wd_child;
        logic       st_ld;
        logic [1:0] st_val;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       rem_ld;
        logic       v_ld;
        logic       v_key;
        logic       lv_ld;
        logic       idx_ld;
        isel_t      isel;
        logic       bld_init;
        logic       bld_dec;
        logic       bld_rd;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       slot_oob;
        logic       r_in;
        logic       l_in;
        logic       idx_zero;
        logic       bld_zero;
        logic       old_lt_key;
        logic       old_gt_key;
        logic       last_gt_rem;
        logic       last_lt_rem;
        logic       child_gt_v;
        logic       rd_gt_v;
        logic       rd_lt_v;
        logic       out_free;
    } stat_t;

endpackage

>>> design/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sequencer for the heap operations: drives memory and register commands.
// ----------------------------------------------------------------------------
module bmh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bmh_pkg::stat_t stat,
    output bmh_pkg::cmd_t  cmd
);

    bmh_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmh_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmh_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bmh_pkg::S_DECODE;
                end
            end
            bmh_pkg::S_DECODE:
            begin
                unique case (stat.op)
                    bmh_pkg::FN_APPEND: state_next = bmh_pkg::S_TOP;
                    bmh_pkg::FN_BUILD:  state_next = bmh_pkg::S_BLD_NEXT;
                    bmh_pkg::FN_DELMAX:
                        state_next = stat.empty ? bmh_pkg::S_TOP : bmh_pkg::S_DM_A;
                    bmh_pkg::FN_UPDATE:
                        state_next = (stat.empty || stat.slot_oob) ? bmh_pkg::S_TOP
                                                                   : bmh_pkg::S_UP_OLD;
                    bmh_pkg::FN_DELAT:
                        state_next = (stat.empty || stat.slot_oob) ? bmh_pkg::S_TOP
                                                                   : bmh_pkg::S_DA_OLD;
                    default: state_next = bmh_pkg::S_TOP;
                endcase
            end
            bmh_pkg::S_DM_A:  state_next = bmh_pkg::S_DM_B;
            bmh_pkg::S_DM_B:  state_next = bmh_pkg::S_SD;
            bmh_pkg::S_UP_OLD:
            begin
                if (stat.old_lt_key)
                begin
                    state_next = bmh_pkg::S_SU;
                end
                else if (stat.old_gt_key)
                begin
                    state_next = bmh_pkg::S_SD;
                end
                else
                begin
                    state_next = bmh_pkg::S_TOP;
                end
            end
            bmh_pkg::S_DA_OLD: state_next = bmh_pkg::S_DA_LAST;
            bmh_pkg::S_DA_LAST:
            begin
                if (stat.slot_oob)
                begin
                    state_next = bmh_pkg::S_TOP;
                end
                else if (stat.last_gt_rem)
                begin
                    state_next = bmh_pkg::S_SU;
                end
                else if (stat.last_lt_rem)
                begin
                    state_next = bmh_pkg::S_SD;
                end
                else
                begin
                    state_next = bmh_pkg::S_TOP;
                end
            end
            bmh_pkg::S_BLD_NEXT:
                state_next = stat.bld_zero ? bmh_pkg::S_TOP : bmh_pkg::S_BLD_LD;
            bmh_pkg::S_BLD_LD: state_next = bmh_pkg::S_SD;
            bmh_pkg::S_SD:
            begin
                if (stat.r_in)
                begin
                    state_next = bmh_pkg::S_SD_L;
                end
                else if (stat.l_in)
                begin
                    state_next = bmh_pkg::S_SD_ONE;
                end
                else
                begin
                    state_next = (stat.op == bmh_pkg::FN_BUILD) ? bmh_pkg::S_BLD_NEXT
                                                                : bmh_pkg::S_TOP;
                end
            end
            bmh_pkg::S_SD_L: state_next = bmh_pkg::S_SD_R;
            bmh_pkg::S_SD_R:
            begin
                if (stat.child_gt_v)
                begin
                    state_next = bmh_pkg::S_SD;
                end
                else
                begin
                    state_next = (stat.op == bmh_pkg::FN_BUILD) ? bmh_pkg::S_BLD_NEXT
                                                                : bmh_pkg::S_TOP;
                end
            end
            bmh_pkg::S_SD_ONE:
            begin
                if (stat.rd_gt_v)
                begin
                    state_next = bmh_pkg::S_SD;
                end
                else
                begin
                    state_next = (stat.op == bmh_pkg::FN_BUILD) ? bmh_pkg::S_BLD_NEXT
                                                                : bmh_pkg::S_TOP;
                end
            end
            bmh_pkg::S_SU:
                state_next = stat.idx_zero ? bmh_pkg::S_TOP : bmh_pkg::S_SU_P;
            bmh_pkg::S_SU_P:
                state_next = stat.rd_lt_v ? bmh_pkg::S_SU : bmh_pkg::S_TOP;
            bmh_pkg::S_TOP: state_next = bmh_pkg::S_FIN;
            bmh_pkg::S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = bmh_pkg::S_IDLE;
                end
            end
            default: state_next = bmh_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.mem    = bmh_pkg::MEM_NONE;
        cmd.adr    = bmh_pkg::ADR_ZERO;
        cmd.wd     = bmh_pkg::WD_V;
        cmd.isel   = bmh_pkg::IDX_ZERO;
        cmd.st_val = bmh_pkg::ST_OK;
        req_ready  = 1'b0;
        unique case (state_reg)
            bmh_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.latch = req_valid;
            end
            bmh_pkg::S_DECODE:
            begin
                cmd.st_ld = 1'b1;
                unique case (stat.op) inside
                    bmh_pkg::FN_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.st_val = bmh_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.mem     = bmh_pkg::MEM_WR;
                            cmd.adr     = bmh_pkg::ADR_CNT;
                            cmd.wd      = bmh_pkg::WD_KEY;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    bmh_pkg::FN_BUILD:
                    begin
                        cmd.bld_init = 1'b1;
                    end
                    bmh_pkg::FN_DELMAX:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_val = bmh_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.mem = bmh_pkg::MEM_RD;
                            cmd.adr = bmh_pkg::ADR_ZERO;
                        end
                    end
                    bmh_pkg::FN_UPDATE, bmh_pkg::FN_DELAT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_val = bmh_pkg::ST_EMPTY;
                        end
                        else if (stat.slot_oob)
                        begin
                            cmd.st_val = bmh_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.mem = bmh_pkg::MEM_RD;
                            cmd.adr = bmh_pkg::ADR_SLOT;
                        end
                    end
                    default: cmd.st_val = bmh_pkg::ST_RANGE;
                endcase
            end
            bmh_pkg::S_DM_A:
            begin
                cmd.rem_ld  = 1'b1;
                cmd.cnt_dec = 1'b1;
                cmd.mem     = bmh_pkg::MEM_RD;
                cmd.adr     = bmh_pkg::ADR_CNTM1;
            end
            bmh_pkg::S_DM_B:
            begin
                cmd.mem    = bmh_pkg::MEM_WR;
                cmd.adr    = bmh_pkg::ADR_CNT;
                cmd.wd     = bmh_pkg::WD_REMOVED;
                cmd.v_ld   = 1'b1;
                cmd.idx_ld = 1'b1;
                cmd.isel   = bmh_pkg::IDX_ZERO;
            end
            bmh_pkg::S_UP_OLD:
            begin
                cmd.v_ld   = 1'b1;
                cmd.v_key  = 1'b1;
                cmd.idx_ld = 1'b1;
                cmd.isel   = bmh_pkg::IDX_SLOT;
            end
            bmh_pkg::S_DA_OLD:
            begin
                cmd.rem_ld  = 1'b1;
                cmd.cnt_dec = 1'b1;
                cmd.mem     = bmh_pkg::MEM_RD;
                cmd.adr     = bmh_pkg::ADR_CNTM1;
            end
            bmh_pkg::S_DA_LAST:
            begin
                cmd.v_ld   = 1'b1;
                cmd.idx_ld = 1'b1;
                cmd.isel   = bmh_pkg::IDX_SLOT;
            end
            bmh_pkg::S_BLD_NEXT:
            begin
                if (!stat.bld_zero)
                begin
                    cmd.bld_dec = 1'b1;
                    cmd.bld_rd  = 1'b1;
                    cmd.mem     = bmh_pkg::MEM_RD;
                end
            end
            bmh_pkg::S_BLD_LD:
            begin
                cmd.v_ld   = 1'b1;
                cmd.idx_ld = 1'b1;
                cmd.isel   = bmh_pkg::IDX_BLD;
            end
            bmh_pkg::S_SD:
            begin
                if (stat.r_in || stat.l_in)
                begin
                    cmd.mem = bmh_pkg::MEM_RD;
                    cmd.adr = bmh_pkg::ADR_LEFT;
                end
                else
                begin
                    cmd.mem = bmh_pkg::MEM_WR;
                    cmd.adr = bmh_pkg::ADR_IDX;
                    cmd.wd  = bmh_pkg::WD_V;
                end
            end
            bmh_pkg::S_SD_L:
            begin
                cmd.lv_ld = 1'b1;
                cmd.mem   = bmh_pkg::MEM_RD;
                cmd.adr   = bmh_pkg::ADR_RIGHT;
            end
            bmh_pkg::S_SD_R:
            begin
                cmd.mem = bmh_pkg::MEM_WR;
                cmd.adr = bmh_pkg::ADR_IDX;
                if (stat.child_gt_v)
                begin
                    cmd.wd_child = 1'b1;
                    cmd.idx_ld   = 1'b1;
                    cmd.isel     = bmh_pkg::IDX_CHILD;
                end
                else
                begin
                    cmd.wd = bmh_pkg::WD_V;
                end
            end
            bmh_pkg::S_SD_ONE:
            begin
                cmd.mem = bmh_pkg::MEM_WR;
                cmd.adr = bmh_pkg::ADR_IDX;
                if (stat.rd_gt_v)
                begin
                    cmd.wd     = bmh_pkg::WD_RDATA;
                    cmd.idx_ld = 1'b1;
                    cmd.isel   = bmh_pkg::IDX_LEFT;
                end
                else
                begin
                    cmd.wd = bmh_pkg::WD_V;
                end
            end
            bmh_pkg::S_SU:
            begin
                if (stat.idx_zero)
                begin
                    cmd.mem = bmh_pkg::MEM_WR;
                    cmd.adr = bmh_pkg::ADR_IDX;
                    cmd.wd  = bmh_pkg::WD_V;
                end
                else
                begin
                    cmd.mem = bmh_pkg::MEM_RD;
                    cmd.adr = bmh_pkg::ADR_PARENT;
                end
            end
            bmh_pkg::S_SU_P:
            begin
                cmd.mem = bmh_pkg::MEM_WR;
                cmd.adr = bmh_pkg::ADR_IDX;
                if (stat.rd_lt_v)
                begin
                    cmd.wd     = bmh_pkg::WD_RDATA;
                    cmd.idx_ld = 1'b1;
                    cmd.isel   = bmh_pkg::IDX_PARENT;
                end
                else
                begin
                    cmd.wd = bmh_pkg::WD_V;
                end
            end
            bmh_pkg::S_TOP:
            begin
                cmd.mem = bmh_pkg::MEM_RD;
                cmd.adr = bmh_pkg::ADR_ZERO;
            end
            bmh_pkg::S_FIN:
            begin
                cmd.out_ld = stat.out_free;
            end
            default: cmd.out_ld = 1'b0;
        endcase
    end

endmodule

>>> design/bmh_dpath.sv
// ----------------------------------------------------------------------------
// bmh_dpath
// Heap store, index and key registers, comparators and the result register.
// ----------------------------------------------------------------------------
module bmh_dpath #(
    parameter int CAPACITY = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bmh_pkg::req_t req,
    input  bmh_pkg::cmd_t cmd,
    output bmh_pkg::stat_t stat,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bmh_pkg::rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int SW = (CW > 10) ? CW : 10;

    logic signed [31:0] mem [CAPACITY];

    logic [2:0]         op_reg;
    logic [9:0]         slot_reg;
    logic signed [31:0] key_reg;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      bld_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] lv_reg;
    logic signed [31:0] removed_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] rdata_reg;
    logic               rsp_valid_reg;
    bmh_pkg::rsp_t      rsp_reg;

    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      lft;
    logic [XW-1:0]      rgt;
    logic [XW-1:0]      par;
    logic [XW-1:0]      addr_x;
    logic [AW-1:0]      addr;
    logic               c_left;
    logic signed [31:0] cv;
    logic [XW-1:0]      ci;
    logic signed [31:0] wdata;
    logic [AW-1:0]      idx_next;
    logic               out_free;

    assign idx_x  = XW'(idx_reg);
    assign cnt_x  = XW'(cnt_reg);
    assign lft    = (idx_x << 1) + XW'(1);
    assign rgt    = lft + XW'(1);
    assign par    = (idx_x - XW'(1)) >> 1;
    assign c_left = lv_reg > rdata_reg;
    assign cv     = c_left ? lv_reg : rdata_reg;
    assign ci     = c_left ? lft : rgt;
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        case (cmd.adr)
            bmh_pkg::ADR_ZERO:   addr_x = '0;
            bmh_pkg::ADR_CNT:    addr_x = cnt_x;
            bmh_pkg::ADR_CNTM1:  addr_x = cnt_x - XW'(1);
            bmh_pkg::ADR_SLOT:   addr_x = XW'(slot_reg);
            bmh_pkg::ADR_IDX:    addr_x = idx_x;
            bmh_pkg::ADR_LEFT:   addr_x = lft;
            bmh_pkg::ADR_RIGHT:  addr_x = rgt;
            bmh_pkg::ADR_PARENT: addr_x = par;
            default:             addr_x = '0;
        endcase
        if (cmd.bld_rd)
        begin
            addr_x = XW'(bld_reg) - XW'(1);
        end
    end

    assign addr = addr_x[AW-1:0];

    always_comb
    begin
        case (cmd.wd)
            bmh_pkg::WD_KEY:     wdata = key_reg;
            bmh_pkg::WD_V:       wdata = v_reg;
            bmh_pkg::WD_REMOVED: wdata = removed_reg;
            bmh_pkg::WD_RDATA:   wdata = rdata_reg;
            default:             wdata = v_reg;
        endcase
        if (cmd.wd_child)
        begin
            wdata = cv;
        end
    end

    always_comb
    begin
        case (cmd.isel)
            bmh_pkg::IDX_ZERO:   idx_next = '0;
            bmh_pkg::IDX_SLOT:   idx_next = AW'(slot_reg);
            bmh_pkg::IDX_LEFT:   idx_next = lft[AW-1:0];
            bmh_pkg::IDX_CHILD:  idx_next = ci[AW-1:0];
            bmh_pkg::IDX_PARENT: idx_next = par[AW-1:0];
            bmh_pkg::IDX_BLD:    idx_next = bld_reg;
            default:             idx_next = '0;
        endcase
    end

    // heap store
    always_ff @(posedge clk)
    begin
        if (cmd.mem == bmh_pkg::MEM_WR)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.mem == bmh_pkg::MEM_RD)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= req.func;
            slot_reg <= req.slot;
            key_reg  <= req.key_in;
        end
        if (cmd.latch)
        begin
            removed_reg <= '0;
        end
        else if (cmd.rem_ld)
        begin
            removed_reg <= rdata_reg;
        end
        if (cmd.st_ld)
        begin
            status_reg <= cmd.st_val;
        end
        if (cmd.v_ld)
        begin
            v_reg <= cmd.v_key ? key_reg : rdata_reg;
        end
        if (cmd.lv_ld)
        begin
            lv_reg <= rdata_reg;
        end
        if (cmd.idx_ld)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.bld_init)
        begin
            bld_reg <= AW'(cnt_reg >> 1);
        end
        else if (cmd.bld_dec)
        begin
            bld_reg <= bld_reg - AW'(1);
        end
        if (cmd.out_ld)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.top_key     <= (cnt_reg != '0) ? rdata_reg : 32'sd0;
            rsp_reg.removed_key <= removed_reg;
            rsp_reg.entry_count <= 11'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.out_ld)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.empty       = (cnt_reg == '0);
        stat.full        = (cnt_reg == CW'(CAPACITY));
        stat.slot_oob    = (SW'(slot_reg) >= SW'(cnt_reg));
        stat.r_in        = (rgt < cnt_x);
        stat.l_in        = (lft < cnt_x);
        stat.idx_zero    = (idx_reg == '0);
        stat.bld_zero    = (bld_reg == '0);
        stat.old_lt_key  = (rdata_reg < key_reg);
        stat.old_gt_key  = (rdata_reg > key_reg);
        stat.last_gt_rem = (rdata_reg > removed_reg);
        stat.last_lt_rem = (rdata_reg < removed_reg);
        stat.child_gt_v  = (v_reg < cv);
        stat.rd_gt_v     = (rdata_reg > v_reg);
        stat.rd_lt_v     = (rdata_reg < v_reg);
        stat.out_free    = out_free;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/binary_max_heap_engine.sv
// ----------------------------------------------------------------------------
// binary_max_heap_engine
// Array-stored binary max-heap of signed 32-bit keys with append, build,
// delete max, update and delete-at operations, one result word per request.
// ----------------------------------------------------------------------------
// latency from acceptance to result grows with each heap level that delete max
//   walks down or that update sinks or raises a key through, on the single-port
//   heap store
// build: each internal node is sunk in turn, from the last one down to the root
// one request at a time; the next is taken the cycle after the result enters
//   the output register, which holds it until rsp_ready
// reset: entry count and handshake state cleared, heap store left as is
module binary_max_heap_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bmh_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bmh_pkg::rsp_t rsp
);

    bmh_pkg::cmd_t  cmd;
    bmh_pkg::stat_t stat;

    bmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bmh_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> design/bmh_checker.sv
// ----------------------------------------------------------------------------
// bmh_checker
// Port-level checks on the heap engine's result words and request handshake.
// ----------------------------------------------------------------------------
module bmh_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input bmh_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bmh_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.entry_count == 11'd0 |-> rsp.top_key == 32'sd0)
        else $error("empty heap shows a nonzero top");

    a_fail_removed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != bmh_pkg::ST_OK |-> rsp.removed_key == 32'sd0)
        else $error("failed request reports a removed key");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == bmh_pkg::ST_EMPTY |-> rsp.entry_count == 11'd0)
        else $error("empty status with entries held");

    a_no_accept_twice: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind binary_max_heap_engine bmh_checker u_bmh_checker (.*);
